FILE: design/cialu_pkg.sv
`timescale 1ns / 1ps

package cialu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int WIDE_WIDTH = 2 * DATA_WIDTH;
    localparam int OP_WIDTH   = 3;
    localparam int ST_WIDTH   = 2;

    localparam logic [OP_WIDTH-1:0] OP_ADD = OP_WIDTH'(0);
    localparam logic [OP_WIDTH-1:0] OP_SUB = OP_WIDTH'(1);
    localparam logic [OP_WIDTH-1:0] OP_NEG = OP_WIDTH'(2);
    localparam logic [OP_WIDTH-1:0] OP_MUL = OP_WIDTH'(3);
    localparam logic [OP_WIDTH-1:0] OP_DIV = OP_WIDTH'(4);
    localparam logic [OP_WIDTH-1:0] OP_REM = OP_WIDTH'(5);

    localparam logic [ST_WIDTH-1:0] ST_OK       = ST_WIDTH'(0);
    localparam logic [ST_WIDTH-1:0] ST_OVERFLOW = ST_WIDTH'(1);
    localparam logic [ST_WIDTH-1:0] ST_DIV_ZERO = ST_WIDTH'(2);

    typedef struct packed {
        logic [OP_WIDTH-1:0]          operation;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_alu_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic [ST_WIDTH-1:0]          status;
    } t_alu_rsp;

    // Per-beat control that rides along the divider stages.
    typedef struct packed {
        logic [OP_WIDTH-1:0]          op;
        logic                         neg_q;
        logic                         neg_r;
        logic                         div_zero;
        logic signed [WIDE_WIDTH-1:0] wide;
    } t_ctl;

    // Restoring divider working set.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dq;
        logic [DATA_WIDTH-1:0] dvs;
    } t_div;

endpackage

FILE: design/checked_int16_alu_unit.sv
// Checked signed integer ALU. Each input beat carries an operation (add, subtract, negate a,
// multiply, divide, remainder) and two signed DATA_WIDTH-bit operands; each beat yields exactly
// one output beat with the exact answer and a status: ok, overflow when the true answer does not
// fit in signed DATA_WIDTH bits, or divide by zero. Division truncates toward zero and the
// remainder takes the sign of the dividend; any non-ok status forces the result to 0, and the
// unused operation codes return 0 with status ok. The block accepts one beat every cycle while
// not stalled and returns beats in order; the divider is a restoring divider that resolves one
// quotient bit per pipeline stage, and every operation travels through the same stages so order
// is kept. A stall on the output freezes the whole pipeline in place; the input stall is raised
// only while a finished beat is held there.
`timescale 1ns / 1ps

module checked_int16_alu_unit import cialu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_alu_req i_in_beat,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_alu_rsp o_out_beat
);

    // Pipeline advance: the output register is empty or being drained.
    logic adv;

    // Stage 1: captured input beat.
    logic     r_s1_vld;
    t_alu_req r_s1_beat;

    // Prep stage results (abs values, add/sub/neg/mul answers).
    t_ctl n_ctl0;
    t_div n_div0;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic signed [WIDE_WIDTH-1:0] a_w;
    logic signed [WIDE_WIDTH-1:0] b_w;
    logic signed [WIDE_WIDTH-1:0] prod;

    // Divider stages: index 0 holds the prepared beat, index DATA_WIDTH the finished quotient.
    logic [DATA_WIDTH:0] r_vl;
    t_ctl                r_ct [0:DATA_WIDTH];
    t_div                r_dv [0:DATA_WIDTH];
    t_div                n_dv [1:DATA_WIDTH];

    // Final fix-up and range check.
    logic [WIDE_WIDTH-1:0]        q_w;
    logic [WIDE_WIDTH-1:0]        rm_w;
    logic [WIDE_WIDTH-1:0]        quot;
    logic [WIDE_WIDTH-1:0]        remd;
    logic [WIDE_WIDTH-1:0]        fin_wide;
    logic [DATA_WIDTH:0]          hi_bits;
    logic                         fits;
    logic [ST_WIDTH-1:0]          fin_st;
    t_alu_rsp                     n_out_beat;

    // Output register.
    logic     r_out_vld;
    t_alu_rsp r_out_beat;

    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = !adv;

    // ---------------------------------------------------------------------------------------
    // Stage 1: register the incoming beat.
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_beat <= i_in_beat;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Prep: exact add/sub/neg/mul at double width, magnitudes and signs for the divider.
    // ---------------------------------------------------------------------------------------
    assign a    = r_s1_beat.operand_a;
    assign b    = r_s1_beat.operand_b;
    assign a_w  = {{DATA_WIDTH{a[DATA_WIDTH-1]}}, a};
    assign b_w  = {{DATA_WIDTH{b[DATA_WIDTH-1]}}, b};
    assign prod = a * b;

    always_comb begin
        n_ctl0.op       = r_s1_beat.operation;
        n_ctl0.neg_q    = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        n_ctl0.neg_r    = a[DATA_WIDTH-1];
        n_ctl0.div_zero = (b == '0);
        unique case (r_s1_beat.operation)
            OP_ADD:  n_ctl0.wide = a_w + b_w;
            OP_SUB:  n_ctl0.wide = a_w - b_w;
            OP_NEG:  n_ctl0.wide = -a_w;
            OP_MUL:  n_ctl0.wide = prod;
            default: n_ctl0.wide = '0;
        endcase

        // Magnitudes fit in DATA_WIDTH unsigned bits, the most negative value included.
        n_div0.rem = '0;
        n_div0.dq  = a[DATA_WIDTH-1] ? DATA_WIDTH'(~a + 1'b1) : DATA_WIDTH'(a);
        n_div0.dvs = b[DATA_WIDTH-1] ? DATA_WIDTH'(~b + 1'b1) : DATA_WIDTH'(b);
    end

    // ---------------------------------------------------------------------------------------
    // Divider: one restoring step per stage. The dividend shifts out of dq from the top while
    // quotient bits shift in at the bottom. The partial remainder stays below the divisor, so
    // the shifted value always fits in DATA_WIDTH bits.
    // ---------------------------------------------------------------------------------------
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
        logic [DATA_WIDTH-1:0] trial;
        logic                  take;

        assign trial = {r_dv[k].rem[DATA_WIDTH-2:0], r_dv[k].dq[DATA_WIDTH-1]};
        assign take  = (trial >= r_dv[k].dvs);

        always_comb begin
            n_dv[k+1].rem = take ? (trial - r_dv[k].dvs) : trial;
            n_dv[k+1].dq  = {r_dv[k].dq[DATA_WIDTH-2:0], take};
            n_dv[k+1].dvs = r_dv[k].dvs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
        end else if (adv) begin
            r_vl <= {r_vl[DATA_WIDTH-1:0], r_s1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ct[0] <= n_ctl0;
            r_dv[0] <= n_div0;
            for (int k = 0; k < DATA_WIDTH; k++) begin
                r_ct[k+1] <= r_ct[k];
                r_dv[k+1] <= n_dv[k+1];
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Final: apply signs to quotient and remainder, pick the answer, check its range.
    // ---------------------------------------------------------------------------------------
    assign q_w  = {{DATA_WIDTH{1'b0}}, r_dv[DATA_WIDTH].dq};
    assign rm_w = {{DATA_WIDTH{1'b0}}, r_dv[DATA_WIDTH].rem};
    assign quot = r_ct[DATA_WIDTH].neg_q ? (~q_w + 1'b1) : q_w;
    assign remd = r_ct[DATA_WIDTH].neg_r ? (~rm_w + 1'b1) : rm_w;

    always_comb begin
        unique case (r_ct[DATA_WIDTH].op)
            OP_DIV:  fin_wide = quot;
            OP_REM:  fin_wide = remd;
            default: fin_wide = r_ct[DATA_WIDTH].wide;
        endcase
    end

    // The answer fits when every bit from the sign bit of the narrow field upward agrees.
    assign hi_bits = fin_wide[WIDE_WIDTH-1:DATA_WIDTH-1];
    assign fits    = (&hi_bits) | ~(|hi_bits);

    always_comb begin
        priority if ((r_ct[DATA_WIDTH].op == OP_DIV || r_ct[DATA_WIDTH].op == OP_REM)
                     && r_ct[DATA_WIDTH].div_zero) begin
            fin_st = ST_DIV_ZERO;
        end else if (!fits) begin
            fin_st = ST_OVERFLOW;
        end else begin
            fin_st = ST_OK;
        end
        n_out_beat.status = fin_st;
        n_out_beat.result = (fin_st == ST_OK) ? fin_wide[DATA_WIDTH-1:0] : '0;
    end

    // Output register: hold the beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vl[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    // ---------------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------------
    a_err_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_OK) |-> (o_out_beat.result == '0))
        else $error("non-ok status with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.status == ST_OK || o_out_beat.status == ST_OVERFLOW
                         || o_out_beat.status == ST_DIV_ZERO))
        else $error("undefined status code");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_vld)
        else $error("accepted beat did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vl))
        else $error("pipeline moved while stalled");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench import cialu_pkg::*; ();

    // The package names only the six real operations; give the two spare codes names too.
    localparam logic [OP_WIDTH-1:0] OP_SPARE6 = OP_WIDTH'(6);
    localparam logic [OP_WIDTH-1:0] OP_SPARE7 = OP_WIDTH'(7);
    localparam logic [OP_WIDTH-1:0] OP_MENU [8] = '{OP_ADD, OP_SUB, OP_NEG, OP_MUL,
                                                    OP_DIV, OP_REM, OP_SPARE6, OP_SPARE7};

    localparam int MAX_VAL = 2 ** (DATA_WIDTH - 1) - 1;
    localparam int MIN_VAL = -(2 ** (DATA_WIDTH - 1));

    // Pipeline depth of the block; the margin for the tail is added where it is used.
    localparam int PIPE_DEPTH = DATA_WIDTH + 3;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_alu_req op;
        t_alu_rsp answer;
    } t_alu_expect;

    // Holds the answers still owed by the block, oldest first, and tallies what went by.
    class alu_answer_book;
        t_alu_expect owed_answers[$];
        int          failures;
        int          checked;
        int          op_count[8];
        int          status_count[4];

        // Work out the exact answer wide, then range-check it at DATA_WIDTH.
        function t_alu_rsp checked_answer(t_alu_req op);
            longint   a;
            longint   b;
            longint   wide;
            longint   lo;
            longint   hi;
            t_alu_rsp rsp;
            a = $signed(op.operand_a);
            b = $signed(op.operand_b);
            wide = 0;
            rsp.status = ST_OK;
            lo = -(longint'(1) <<< (DATA_WIDTH - 1));
            hi = -lo - 1;
            unique case (op.operation)
                OP_ADD: wide = a + b;
                OP_SUB: wide = a - b;
                OP_NEG: wide = -a;
                OP_MUL: wide = a * b;
                OP_DIV: begin
                    if (b == 0) rsp.status = ST_DIV_ZERO;
                    else wide = a / b;
                end
                OP_REM: begin
                    if (b == 0) rsp.status = ST_DIV_ZERO;
                    else wide = a % b;
                end
                default: wide = 0;
            endcase
            if (rsp.status == ST_OK && (wide < lo || wide > hi)) rsp.status = ST_OVERFLOW;
            if (rsp.status != ST_OK) wide = 0;
            rsp.result = DATA_WIDTH'(wide);
            return rsp;
        endfunction

        function void note_operation(t_alu_req op);
            t_alu_expect entry;
            entry.op = op;
            entry.answer = checked_answer(op);
            owed_answers.push_back(entry);
            op_count[op.operation]++;
        endfunction

        function void check_answer(t_alu_rsp got);
            t_alu_expect want;
            if (owed_answers.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected beat: result %0d status %0d", $realtime,
                             got.result, got.status);
                return;
            end
            want = owed_answers.pop_front();
            checked++;
            status_count[got.status]++;
            if (got.result !== want.answer.result || got.status !== want.answer.status) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: mismatch op %0d a %0d b %0d: expected %0d/%0d, got %0d/%0d",
                             $realtime, want.op.operation, want.op.operand_a,
                             want.op.operand_b, want.answer.result, want.answer.status,
                             got.result, got.status);
            end
        endfunction

        function int outstanding();
            return owed_answers.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_alu_req i_in_beat = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_alu_rsp o_out_beat;

    // Idling odds in percent per cycle, swept across the run.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    alu_answer_book book = new();

    checked_int16_alu_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: raise stall at random, one decision per cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Monitor both channels on the edge; all bench drives are nonblocking, so the values seen
    // here are the ones the block sampled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) book.note_operation(i_in_beat);
            if (o_out_valid && !i_out_stall) book.check_answer(o_out_beat);
        end
    end

    // Present one beat, possibly after idle cycles, and hold it until accepted.
    task automatic send_op(input logic [OP_WIDTH-1:0] op, input int a, input int b);
        t_alu_req req;
        req.operation = op;
        req.operand_a = DATA_WIDTH'(a);
        req.operand_b = DATA_WIDTH'(b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed answer has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.outstanding() != 0);
    endtask

    // Favor the corners and small values so products and quotients often land in range.
    function automatic int pick_operand();
        unique case ($urandom_range(9))
            0: return MAX_VAL;
            1: return MIN_VAL;
            2: return 0;
            3: return $urandom_range(1) ? 1 : -1;
            4, 5: return int'($urandom_range(400)) - 200;
            default: return int'($urandom());
        endcase
    endfunction

    task automatic run_random(input int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(19);
            // Keep the spare codes rare; the rest spread evenly over the six operations.
            send_op(sel < 18 ? OP_MENU[sel % 6] : OP_MENU[sel - 12],
                    pick_operand(), pick_operand());
        end
    endtask

    task automatic run_directed();
        // Add: both overflow directions, extremes cancelling, zero.
        send_op(OP_ADD, MAX_VAL, 1);
        send_op(OP_ADD, MIN_VAL, -1);
        send_op(OP_ADD, MAX_VAL, MIN_VAL);
        send_op(OP_ADD, 0, 0);
        // Subtract: overflow both ways, exact zero.
        send_op(OP_SUB, MIN_VAL, 1);
        send_op(OP_SUB, 0, MIN_VAL);
        send_op(OP_SUB, MAX_VAL, MAX_VAL);
        // Negate: the most negative value cannot be negated; b must be ignored.
        send_op(OP_NEG, MIN_VAL, 5);
        send_op(OP_NEG, MAX_VAL, 0);
        send_op(OP_NEG, 0, -1);
        // Multiply: just past the top, exactly the bottom, large products.
        send_op(OP_MUL, 256, 128);
        send_op(OP_MUL, -256, 128);
        send_op(OP_MUL, MIN_VAL, MIN_VAL);
        send_op(OP_MUL, -1, MIN_VAL);
        send_op(OP_MUL, 181, 181);
        // Divide: most negative by minus one, zero divisor, truncation toward zero.
        send_op(OP_DIV, MIN_VAL, -1);
        send_op(OP_DIV, 7, 0);
        send_op(OP_DIV, -7, 2);
        send_op(OP_DIV, MAX_VAL, MIN_VAL);
        send_op(OP_DIV, MIN_VAL, 1);
        // Remainder: sign follows the dividend, zero divisor, most negative by minus one.
        send_op(OP_REM, -7, 2);
        send_op(OP_REM, 7, -2);
        send_op(OP_REM, 5, 0);
        send_op(OP_REM, MIN_VAL, -1);
        // Spare codes return zero with status ok.
        send_op(OP_SPARE6, MAX_VAL, MIN_VAL);
        send_op(OP_SPARE7, -1, -1);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver stalls heavily.
        src_idle_pct = 16;
        sink_stall_pct = 56;
        run_directed();
        run_random(283);
        hold_until_drained();

        // Swap the pressure: sparse input, mostly ready output.
        src_idle_pct = 56;
        sink_stall_pct = 16;
        run_random(283);
        hold_until_drained();

        // Full rate both ways.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(284);
        hold_until_drained();

        // Let any stray beat surface before judging.
        repeat (PIPE_DEPTH + 24) @(posedge i_clk);

        $display("covered %0d beats: add %0d sub %0d neg %0d mul %0d div %0d rem %0d spare %0d",
                 book.checked, book.op_count[OP_ADD], book.op_count[OP_SUB],
                 book.op_count[OP_NEG], book.op_count[OP_MUL], book.op_count[OP_DIV],
                 book.op_count[OP_REM], book.op_count[OP_SPARE6] + book.op_count[OP_SPARE7]);
        $display("status seen: ok %0d, overflow %0d, divide by zero %0d; %0d failures",
                 book.status_count[ST_OK], book.status_count[ST_OVERFLOW],
                 book.status_count[ST_DIV_ZERO], book.failures);
        if (book.failures == 0 && book.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 900 beats, heavy stalls, 19-stage pipe).
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
